// ----- hdl/sspc_pkg.sv -----
package sspc_pkg;

  // angle limits in degrees
  localparam logic [7:0] LimitHigh = 8'd180;
  localparam logic [7:0] LimitLow  = 8'd25;

  // control phase codes as seen on control_phase_o
  localparam logic [1:0] PhaseWait    = 2'd0;
  localparam logic [1:0] PhaseToEnd   = 2'd1;
  localparam logic [1:0] PhaseToLimit = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegEndPosition = 2'd0;
  localparam logic [1:0] RegReversed    = 2'd1;
  localparam logic [1:0] RegStepDelay   = 2'd2;
  localparam logic [1:0] RegAuxMode     = 2'd3;

  // aux pin modes
  localparam logic [1:0] AuxOff     = 2'd0;
  localparam logic [1:0] AuxNormal  = 2'd1;
  localparam logic [1:0] AuxInverse = 2'd2;
  // stray mode, leaves the pin alone like off
  localparam logic [1:0] AuxStray   = 2'd3;

endpackage

// ----- hdl/servo_slew_position_controller_top.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------------------
// input     | in_valid_i / in_ready_o   | function_on_i
// result    | out_valid_o / out_ready_i | servo_position_o, aux_pin_o, control_phase_o
// config    | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// one tick beat per cycle while in_ready_o; its result shows in the next cycle
// the state registers double as the result register, so the logic between
//   them is one 8-bit increment, four 8-bit compares and a +/-1 step
// in_ready_o stays high while the result register is empty or being taken
// reset: phase waiting, position 25, aux pin low, last level low, registers at
//   their reset values, no result beat pending
module servo_slew_position_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // tick channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       function_on_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] servo_position_o,
  output logic       aux_pin_o,
  output logic [1:0] control_phase_o,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    StWait    = sspc_pkg::PhaseWait,
    StToEnd   = sspc_pkg::PhaseToEnd,
    StToLimit = sspc_pkg::PhaseToLimit
  } phase_e;

  // configuration registers
  logic [7:0] end_pos_q;
  logic       reversed_q;
  logic [7:0] step_delay_q;
  logic [1:0] aux_mode_q;

  // controller state, also the result register
  phase_e     phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic       last_level_q, last_level_d;
  logic [7:0] elapsed_q, elapsed_d;
  logic       aux_q, aux_d;
  logic       out_valid_q;

  logic       accept;
  logic [7:0] limit_pos;
  logic [7:0] target;
  logic [7:0] elapsed_inc;
  logic       step_now;

  // result register empty or drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_pos_q    <= sspc_pkg::LimitLow;
      reversed_q   <= 1'b0;
      step_delay_q <= 8'd0;
      aux_mode_q   <= sspc_pkg::AuxOff;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sspc_pkg::RegEndPosition: end_pos_q    <= cfg_wdata_i;
        sspc_pkg::RegReversed:    reversed_q   <= cfg_wdata_i[0];
        sspc_pkg::RegStepDelay:   step_delay_q <= cfg_wdata_i;
        sspc_pkg::RegAuxMode:     aux_mode_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign limit_pos   = reversed_q ? sspc_pkg::LimitHigh : sspc_pkg::LimitLow;
  assign target      = (phase_q == StToEnd) ? end_pos_q : limit_pos;
  // saturating tick count inside the delay interval
  assign elapsed_inc = (elapsed_q == 8'hFF) ? elapsed_q : elapsed_q + 8'd1;
  assign step_now    = (elapsed_inc >= step_delay_q);

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    last_level_d = last_level_q;
    elapsed_d    = elapsed_q;
    aux_d        = aux_q;
    case (phase_q)
      StToEnd, StToLimit: begin
        elapsed_d = elapsed_inc;
        if (step_now) begin
          elapsed_d = 8'd0;
          if (pos_q < target) begin
            pos_d = pos_q + 8'd1;
          end else if (pos_q > target) begin
            pos_d = pos_q - 8'd1;
          end else begin
            // target reached: move ends, aux pin follows mode
            phase_d = StWait;
            if (aux_mode_q == sspc_pkg::AuxNormal) begin
              aux_d = (phase_q == StToEnd);
            end else if (aux_mode_q == sspc_pkg::AuxInverse) begin
              aux_d = (phase_q == StToLimit);
            end
          end
        end
      end
      default: begin
        // waiting: an edge of the switch level starts a move
        phase_d = StWait;
        if (function_on_i != last_level_q) begin
          phase_d      = function_on_i ? StToEnd : StToLimit;
          elapsed_d    = 8'd0;
          last_level_d = function_on_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= StWait;
      pos_q        <= sspc_pkg::LimitLow;
      last_level_q <= 1'b0;
      elapsed_q    <= 8'd0;
      aux_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        pos_q        <= pos_d;
        last_level_q <= last_level_d;
        elapsed_q    <= elapsed_d;
        aux_q        <= aux_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign servo_position_o = pos_q;
  assign aux_pin_o        = aux_q;
  assign control_phase_o  = phase_q;

endmodule

// ----- hdl/sspc_checker.sv -----
module sspc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] servo_position_o,
  input logic       aux_pin_o,
  input logic [1:0] control_phase_o
);

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(servo_position_o) && $stable(aux_pin_o) && $stable(control_phase_o))
    else $error("result payload changed while stalled");

  // an accepted tick always yields a result beat next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("tick accepted without result beat");

  // no tick accepted, no change of position or aux pin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) |=> $stable(servo_position_o) && $stable(aux_pin_o))
    else $error("state changed without a tick");

  // the tick that ends a move leaves the position where it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && control_phase_o != sspc_pkg::PhaseWait ##1
      control_phase_o == sspc_pkg::PhaseWait |-> $stable(servo_position_o))
    else $error("position moved on the ending tick");

endmodule

bind servo_slew_position_controller_top sspc_checker u_sspc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .servo_position_o (servo_position_o),
  .aux_pin_o        (aux_pin_o),
  .control_phase_o  (control_phase_o)
);
